FILE: rtl/eqm_pkg.sv
// Package of the empirical quantile and mean engine.
// Holds request and status codes, field widths and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eqm_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned SumW    = 40;
  localparam int unsigned RankW   = 8;
  localparam int unsigned WeightW = 17;
  localparam int unsigned ProdW   = 50;
  localparam logic [WeightW-1:0] WeightOne = 17'd65536;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/eqm_if.sv
// Request and response channel interfaces of the quantile engine.
// Depends on eqm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface eqm_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic signed [eqm_pkg::ValueW-1:0]   sample_value;
  logic [eqm_pkg::RankW-1:0]           first_rank;
  logic [eqm_pkg::RankW-1:0]           second_rank;
  logic [eqm_pkg::WeightW-1:0]         weight;

  modport source (output valid, req_type, sample_value, first_rank, second_rank, weight,
                  input ready);
  modport sink (input valid, req_type, sample_value, first_rank, second_rank, weight,
                output ready);
endinterface

interface eqm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [eqm_pkg::ValueW-1:0]   quantile_value;
  logic signed [eqm_pkg::ValueW-1:0]   mean_value;
  logic [1:0]                          status;

  modport source (output valid, quantile_value, mean_value, status, input ready);
  modport sink (input valid, quantile_value, mean_value, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/eqm_cell.sv
// One cell of the sorted sample chain.
// Depends on eqm_pkg; neighbors are wired by the top level.
`timescale 1ns / 1ps
`default_nettype none

module eqm_cell (
  input  wire                                  clk_i,
  input  wire eqm_pkg::cell_ctrl_t             ctrl_i,
  input  wire                                  occupied_i,
  input  wire                                  tail_i,
  input  wire signed [eqm_pkg::ValueW-1:0]     sample_i,
  input  wire signed [eqm_pkg::ValueW-1:0]     left_value_i,
  input  wire                                  left_gt_i,
  input  wire signed [eqm_pkg::ValueW-1:0]     right_value_i,
  output logic signed [eqm_pkg::ValueW-1:0]    value_o,
  output logic                                 gt_o
);

  logic signed [eqm_pkg::ValueW-1:0] value_q, value_d;

  assign gt_o    = occupied_i && (value_q > sample_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.rotate) begin
      value_d = right_value_i;
    end else if (ctrl_i.load && (gt_o || tail_i)) begin
      // take the left neighbor when it moves up too, else the new sample
      value_d = left_gt_i ? left_value_i : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

FILE: rtl/eqm_divider.sv
// Restoring divider for the series mean, one quotient bit per cycle.
// Depends on eqm_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module eqm_divider #(
  parameter int unsigned CountW = 9
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  input  wire signed [eqm_pkg::SumW-1:0]     sum_i,
  input  wire [CountW-1:0]                   count_i,
  output logic                               busy_o,
  output logic signed [eqm_pkg::ValueW-1:0]  mean_o
);

  localparam int unsigned SW = eqm_pkg::SumW;
  localparam int unsigned StepW = $clog2(SW + 1);

  logic [StepW-1:0]  step_q;
  logic              busy_q, neg_q;
  logic [SW-1:0]     quo_q;
  logic [CountW-1:0] rem_q, den_q;
  logic [CountW:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[SW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(SW);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == StepW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= sum_i[SW-1];
      quo_q <= sum_i[SW-1] ? (~sum_i + 1'b1) : sum_i;
      rem_q <= '0;
      den_q <= count_i;
    end else if (busy_q) begin
      rem_q <= ge ? CountW'(rem_sh - {1'b0, den_q}) : CountW'(rem_sh);
      quo_q <= {quo_q[SW-2:0], ge};
    end
  end

  // saturate the truncated quotient to 32 bits
  always_comb begin
    if (neg_q) begin
      mean_o = (quo_q > SW'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(quo_q[31:0]);
    end else begin
      mean_o = (quo_q > SW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/empirical_quantile_mean_engine_top.sv
// Load beat: one sample per cycle into the sorted cell chain while the engine is idle and the result slot is free.
// Query beat: the chain rotates once through all cells to pick both ranks while the
//   divider forms the mean, then S_MUL forms the weighted products and S_OUT writes the result.
// Clear, empty-series and full-store beats are handled in S_IDLE without a scan.
// Reset empties the series (count and sum zero); cell contents are undefined until loaded.
// Depends on eqm_pkg, eqm_if, eqm_cell and eqm_divider.
`timescale 1ns / 1ps
`default_nettype none

module empirical_quantile_mean_engine_top #(
  parameter int unsigned SAMPLE_DEPTH = 256
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  eqm_req_if.sink    req_if,
  eqm_rsp_if.source  rsp_if
);

  localparam int unsigned VW = eqm_pkg::ValueW;
  localparam int unsigned CW = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned RW = (CW > eqm_pkg::RankW) ? CW : eqm_pkg::RankW;
  localparam int unsigned PW = eqm_pkg::ProdW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_OUT
  } state_e;

  state_e state_q;

  logic [CW-1:0]                 count_q, rot_q;
  logic signed [eqm_pkg::SumW-1:0] sum_q;
  logic [eqm_pkg::RankW-1:0]     r1_q, r2_q;
  logic [eqm_pkg::WeightW-1:0]   w_q;
  logic                          same_q;
  eqm_pkg::status_e              stat_q;
  logic signed [VW-1:0]          a_q, b_q;
  logic signed [PW-1:0]          pa_q, pb_q;

  logic                          out_valid_q;
  logic signed [VW-1:0]          out_q_q, out_m_q;
  eqm_pkg::status_e              out_st_q;

  logic slot_free, accept, store_full, do_load, do_rotate, out_set;
  logic div_start, div_busy;
  logic signed [VW-1:0] mean;
  eqm_pkg::req_type_e req;
  eqm_pkg::cell_ctrl_t cell_ctrl;

  logic signed [VW-1:0] cell_v [SAMPLE_DEPTH];
  logic                 cell_gt [SAMPLE_DEPTH];

  logic signed [PW-1:0] mix;
  logic [eqm_pkg::WeightW-1:0] w_sat;

  // a pending result may leave in the same cycle that a new one is written
  assign slot_free  = !out_valid_q || rsp_if.ready;
  assign req_if.ready = (state_q == S_IDLE) && slot_free;
  assign accept     = req_if.valid && req_if.ready;
  assign req        = eqm_pkg::req_type_e'(req_if.req_type);
  assign store_full = count_q == CW'(SAMPLE_DEPTH);
  assign do_load    = accept && (req == eqm_pkg::REQ_LOAD) && !store_full;
  assign do_rotate  = (state_q == S_SCAN) && (rot_q != CW'(SAMPLE_DEPTH));
  assign div_start  = accept && (req == eqm_pkg::REQ_QUERY) && (count_q != '0);
  assign cell_ctrl  = '{load: do_load, rotate: do_rotate};

  // load the result register on a one-beat answer or at the end of a query
  assign out_set = (accept && (((req == eqm_pkg::REQ_LOAD) && store_full) ||
                               ((req == eqm_pkg::REQ_QUERY) && (count_q == '0)))) ||
                   ((state_q == S_OUT) && slot_free);

  assign w_sat = (req_if.weight > eqm_pkg::WeightOne) ? eqm_pkg::WeightOne : req_if.weight;

  // Sorted chain: each cell compares the new sample with its own value and
  // shifts up from its left neighbor on load; on query the whole row rotates
  // toward cell 0 so that rank k sits in cell 0 after k rotations.
  for (genvar i = 0; i < SAMPLE_DEPTH; i++) begin : g_cell
    eqm_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .occupied_i   (CW'(i) < count_q),
      .tail_i       (CW'(i) == count_q),
      .sample_i     (req_if.sample_value),
      .left_value_i (cell_v[(i + SAMPLE_DEPTH - 1) % SAMPLE_DEPTH]),
      .left_gt_i    ((i == 0) ? 1'b0 : cell_gt[(i + SAMPLE_DEPTH - 1) % SAMPLE_DEPTH]),
      .right_value_i(cell_v[(i + 1) % SAMPLE_DEPTH]),
      .value_o      (cell_v[i]),
      .gt_o         (cell_gt[i])
    );
  end

  eqm_divider #(.CountW(CW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sum_i  (sum_q),
    .count_i(count_q),
    .busy_o (div_busy),
    .mean_o (mean)
  );

  assign mix = pa_q + pb_q;

  // series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else if (accept && (req == eqm_pkg::REQ_CLEAR)) begin
      count_q <= '0;
      sum_q   <= '0;
    end else if (do_load) begin
      count_q <= count_q + 1'b1;
      sum_q   <= sum_q + eqm_pkg::SumW'(req_if.sample_value);
    end
  end

  // query sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rot_q       <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (rsp_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (req == eqm_pkg::REQ_LOAD) && store_full) begin
            out_q_q     <= '0;
            out_m_q     <= '0;
            out_st_q    <= eqm_pkg::ST_FULL;
          end else if (accept && (req == eqm_pkg::REQ_QUERY)) begin
            if (count_q == '0) begin
              out_q_q     <= '0;
              out_m_q     <= '0;
              out_st_q    <= eqm_pkg::ST_EMPTY;
            end else begin
              state_q <= S_SCAN;
              rot_q   <= '0;
              r1_q    <= req_if.first_rank;
              r2_q    <= req_if.second_rank;
              w_q     <= w_sat;
              same_q  <= req_if.first_rank == req_if.second_rank;
              stat_q  <= ((RW'(req_if.first_rank) >= RW'(count_q)) ||
                          (RW'(req_if.second_rank) >= RW'(count_q))) ?
                         eqm_pkg::ST_RANGE : eqm_pkg::ST_OK;
            end
          end
        end
        S_SCAN: begin
          if (do_rotate) begin
            // capture the ranks as they pass cell 0
            if (RW'(rot_q) == RW'(r1_q)) a_q <= cell_v[0];
            if (RW'(rot_q) == RW'(r2_q)) b_q <= cell_v[0];
            rot_q <= rot_q + 1'b1;
          end else if (!div_busy) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          pa_q    <= $signed({1'b0, w_q}) * a_q;
          pb_q    <= $signed({1'b0, eqm_pkg::WeightW'(eqm_pkg::WeightOne - w_q)}) * b_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the result register frees up
          if (slot_free) begin
            out_m_q     <= mean;
            out_st_q    <= stat_q;
            if (stat_q != eqm_pkg::ST_OK) begin
              out_q_q <= '0;
            end else if (same_q) begin
              out_q_q <= a_q;
            end else begin
              out_q_q <= VW'(mix >>> 16);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_if.valid          = out_valid_q;
  assign rsp_if.quantile_value = out_q_q;
  assign rsp_if.mean_value     = out_m_q;
  assign rsp_if.status         = out_st_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SAMPLE_DEPTH))
    else $error("sample count beyond store depth");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_if.ready)
    else $error("request taken during a query");

  a_load_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |=> (count_q == $past(count_q) + 1'b1))
    else $error("load did not advance the count");

  a_rotate_full_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && !do_rotate && !div_busy) |-> (rot_q == CW'(SAMPLE_DEPTH)))
    else $error("query left the scan before a full turn");

endmodule

`default_nettype wire

FILE: tb/sv/eqm_tb_if.sv
// Testbench package of the quantile engine: the request beat as stimulus builds it.
// Depends on eqm_pkg.
`timescale 1ns / 1ps
package eqm_tb_pkg;

  // One request beat as the stimulus side builds it.
  typedef struct packed {
    eqm_pkg::req_type_e                req;
    logic signed [eqm_pkg::ValueW-1:0] sample;
    logic [eqm_pkg::RankW-1:0]         rank_a;
    logic [eqm_pkg::RankW-1:0]         rank_b;
    logic [eqm_pkg::WeightW-1:0]       weight;
  } eqm_beat_t;
endpackage

FILE: tb/sv/eqm_checker.sv
// Quantile engine checker: watches both channels, keeps a sorted shadow series,
// predicts every response and compares it. Depends on eqm_pkg and eqm_if.
`timescale 1ns / 1ps
module eqm_checker #(
  parameter int unsigned SAMPLE_DEPTH = 256
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  eqm_req_if         req_if,
  eqm_rsp_if         rsp_if,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic signed [31:0] quant;
    logic signed [31:0] mean;
    eqm_pkg::status_e   st;
  } answer_t;

  logic signed [31:0] sorted_series[$];
  logic signed [39:0] series_sum;
  answer_t            answers_due[$];

  function automatic logic signed [31:0] series_mean();
    longint m;
    m = longint'(series_sum) / longint'(sorted_series.size());
    if (m > 64'sd2147483647) m = 64'sd2147483647;
    if (m < -64'sd2147483648) m = -64'sd2147483648;
    return m[31:0];
  endfunction

  task automatic absorb_request(input logic [1:0] rt, input logic signed [31:0] x,
                                input logic [7:0] ra, input logic [7:0] rb,
                                input logic [16:0] w_in);
    answer_t a;
    longint  w, acc;
    int      pos;
    a = '{quant: '0, mean: '0, st: eqm_pkg::ST_OK};
    case (rt)
      eqm_pkg::REQ_LOAD: begin
        if (sorted_series.size() >= SAMPLE_DEPTH) begin
          a.st = eqm_pkg::ST_FULL;
          answers_due.push_back(a);
        end else begin
          pos = sorted_series.size();
          while (pos > 0 && sorted_series[pos-1] > x) pos--;
          sorted_series.insert(pos, x);
          series_sum = series_sum + 40'(x);
        end
      end
      eqm_pkg::REQ_QUERY: begin
        if (sorted_series.size() == 0) begin
          a.st = eqm_pkg::ST_EMPTY;
        end else begin
          a.mean = series_mean();
          if (ra >= sorted_series.size() || rb >= sorted_series.size()) begin
            a.st = eqm_pkg::ST_RANGE;
          end else if (ra == rb) begin
            a.quant = sorted_series[ra];
          end else begin
            w = (w_in > 17'd65536) ? 65536 : longint'(w_in);
            acc = w * longint'(sorted_series[ra]) + (65536 - w) * longint'(sorted_series[rb]);
            acc = acc >>> 16;
            a.quant = acc[31:0];
          end
        end
        answers_due.push_back(a);
      end
      eqm_pkg::REQ_CLEAR: begin
        sorted_series.delete();
        series_sum = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t e;
    int      errs;
    if (!rst_ni) begin
      sorted_series.delete();
      answers_due.delete();
      series_sum = '0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      errs = 0;
      if (rsp_if.valid && rsp_if.ready) begin
        if (answers_due.size() == 0) begin
          $error("unexpected response beat");
          errs++;
        end else begin
          e = answers_due.pop_front();
          if (rsp_if.quantile_value !== e.quant) begin
            $error("quantile_value expected %0d actual %0d", e.quant, rsp_if.quantile_value);
            errs++;
          end
          if (rsp_if.mean_value !== e.mean) begin
            $error("mean_value expected %0d actual %0d", e.mean, rsp_if.mean_value);
            errs++;
          end
          if (rsp_if.status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, rsp_if.status);
            errs++;
          end
        end
      end
      if (req_if.valid && req_if.ready)
        absorb_request(req_if.req_type, req_if.sample_value, req_if.first_rank,
                       req_if.second_rank, req_if.weight);
      fail_count_o <= fail_count_o + errs;
      pending_o    <= answers_due.size();
    end
  end

endmodule

FILE: tb/sv/empirical_quantile_mean_engine_top_tb.sv
// Top of the quantile engine testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on eqm_pkg, eqm_tb_pkg, eqm_if and eqm_checker.
`timescale 1ns / 1ps
module empirical_quantile_mean_engine_top_tb;

  localparam int unsigned Depth = 256;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  // Idle odds in percent for each side; stall_hold forces a long receiver hold-off.
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   stall_hold;

  eqm_req_if req_if ();
  eqm_rsp_if rsp_if ();

  empirical_quantile_mean_engine_top #(.SAMPLE_DEPTH(Depth)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if),
    .rsp_if (rsp_if)
  );

  eqm_checker #(.SAMPLE_DEPTH(Depth)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_if       (req_if),
    .rsp_if       (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Safety net: each query takes a full turn of the chain and stalls come on top;
  // the limit leaves wide room for a correct run.
  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random back-pressure, suspended as a whole while stall_hold is set.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one beat, idling first at random, and hold it until the block takes it.
  task automatic send_beat(input eqm_tb_pkg::eqm_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= b.req;
    req_if.sample_value <= b.sample;
    req_if.first_rank   <= b.rank_a;
    req_if.second_rank  <= b.rank_b;
    req_if.weight       <= b.weight;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic eqm_tb_pkg::eqm_beat_t make_beat(input eqm_pkg::req_type_e r,
                                                      input logic [31:0] x,
                                                      input logic [7:0] ra,
                                                      input logic [7:0] rb,
                                                      input logic [16:0] w);
    return '{req: r, sample: x, rank_a: ra, rank_b: rb, weight: w};
  endfunction

  // Random sample: mostly wide values, sometimes extremes or small magnitudes.
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(4))
      0: return 17'd0;
      1: return eqm_pkg::WeightOne;
      2: return 17'(17'h10000 + $urandom_range(65535));  // above one, saturates
      default: return 17'($urandom_range(65535));
    endcase
  endfunction

  // Series of random length with queries mixed in; count tracks the live size so
  // most ranks land in range.
  task automatic run_series(input int n_items, input int max_len);
    int count, len;
    len = $urandom_range(max_len, 1);
    count = 0;
    send_beat(make_beat(eqm_pkg::REQ_CLEAR, $urandom, 8'($urandom), 8'($urandom),
                        17'($urandom)));
    repeat (n_items) begin
      case ($urandom_range(19))
        0, 1, 2, 3: begin
          if (count == 0) count = 1;
          send_beat(make_beat(eqm_pkg::REQ_QUERY, $urandom,
                              8'(($urandom_range(9) == 0) ? $urandom
                                                          : $urandom_range(count-1)),
                              8'(($urandom_range(9) == 0) ? $urandom
                                                          : $urandom_range(count-1)),
                              rand_weight()));
        end
        4: send_beat(make_beat(eqm_pkg::REQ_NONE, $urandom, 8'($urandom), 8'($urandom),
                               17'($urandom)));
        5: if ($urandom_range(3) == 0) begin
             send_beat(make_beat(eqm_pkg::REQ_CLEAR, $urandom, 8'($urandom), 8'($urandom),
                                 17'($urandom)));
             count = 0;
           end
        default: if (count < len || $urandom_range(7) == 0) begin
          send_beat(make_beat(eqm_pkg::REQ_LOAD, rand_sample(), 8'($urandom), 8'($urandom),
                              17'($urandom)));
          if (count < Depth) count++;
        end
      endcase
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int i;
    stall_hold    = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 56;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = eqm_pkg::REQ_NONE;
    req_if.sample_value = '0;
    req_if.first_rank   = '0;
    req_if.second_rank  = '0;
    req_if.weight       = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: query on empty series, extremes, equal ranks, out of range,
    // weight above one, unused request type.
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 0, 0, 0));
    send_beat(make_beat(eqm_pkg::REQ_LOAD, 32'h7fffffff, 0, 0, 0));
    send_beat(make_beat(eqm_pkg::REQ_LOAD, 32'h80000000, 8'hff, 8'hff, 17'h1ffff));
    send_beat(make_beat(eqm_pkg::REQ_LOAD, 32'h00010000, 0, 0, 0));
    send_beat(make_beat(eqm_pkg::REQ_NONE, 32'hffffffff, 8'hff, 8'hff, 17'h1ffff));
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 0, 2, 0));
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 0, 2, eqm_pkg::WeightOne));
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 2, 0, 17'h1ffff));
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 1, 1, 17'h08000));
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 0, 1, 17'h08000));
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 3, 0, 0));
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 0, 8'hff, 0));
    send_beat(make_beat(eqm_pkg::REQ_CLEAR, 0, 0, 0, 0));
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 0, 0, 0));
    // Push the mean to the top of its range with large positives.
    for (i = 0; i < 3; i++)
      send_beat(make_beat(eqm_pkg::REQ_LOAD, 32'h7fffffff, 0, 0, 0));
    send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 0, 2, 17'h0ffff));
    drain();

    // Fill the store past its depth while the receiver holds off; then drain.
    send_beat(make_beat(eqm_pkg::REQ_CLEAR, 0, 0, 0, 0));
    for (i = 0; i < Depth; i++)
      send_beat(make_beat(eqm_pkg::REQ_LOAD, rand_sample(), 0, 0, 0));
    stall_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        stall_hold = 1'b0;
      end
      begin
        for (i = 0; i < 6; i++)
          send_beat(make_beat(eqm_pkg::REQ_LOAD, rand_sample(), 0, 0, 0));
        send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 0, 8'hff, rand_weight()));
        send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 8'hff, 0, rand_weight()));
        send_beat(make_beat(eqm_pkg::REQ_QUERY, 0, 8'd100, 8'd7, rand_weight()));
      end
    join
    drain();

    // Random phases with rotating idle profiles; pause for full drain between.
    send_idle_pct = 21; recv_idle_pct = 56;
    for (i = 0; i < 8; i++) run_series(55, ($urandom_range(3) == 0) ? Depth : 20);
    drain();
    send_idle_pct = 56; recv_idle_pct = 21;
    for (i = 0; i < 8; i++) run_series(55, ($urandom_range(3) == 0) ? Depth : 20);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (i = 0; i < 8; i++) run_series(55, ($urandom_range(3) == 0) ? Depth : 20);
    drain();

    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

FILE: empirical_quantile_mean_engine_top.f
rtl/eqm_pkg.sv
rtl/eqm_if.sv
rtl/eqm_cell.sv
rtl/eqm_divider.sv
rtl/empirical_quantile_mean_engine_top.sv
tb/sv/eqm_tb_if.sv
tb/sv/eqm_checker.sv
tb/sv/empirical_quantile_mean_engine_top_tb.sv
